// File: src/olist_pkg.sv
package olist_pkg;

    // Request codes
    localparam logic [2:0] REQ_INS_HEAD = 3'd0;
    localparam logic [2:0] REQ_INS_TAIL = 3'd1;
    localparam logic [2:0] REQ_INS_POS  = 3'd2;
    localparam logic [2:0] REQ_DEL_POS  = 3'd3;
    localparam logic [2:0] REQ_DEL_VAL  = 3'd4;
    localparam logic [2:0] REQ_DUMP     = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    // Most results a single dump emits
    localparam int MAX_RESULTS = 16;

    // Fixed field widths
    localparam int VALUE_W = 32;
    localparam int INDEX_W = 4;
    localparam int COUNT_W = 5;

    typedef logic signed [VALUE_W-1:0] value_t;

endpackage

// File: src/ordered_list_engine.sv
// Ordered list engine: a bounded list of signed 32-bit words held in one
// synchronous RAM in list order (index 0 is the head).
// Input channel (s_valid/s_ready): one request per transaction - insert at
// head, tail or position, delete at position, delete every match of a value,
// or dump. Result channel (m_valid/m_ready): a dump gives one transaction per
// entry (at most 16) with m_last on the final one; every other request gives
// exactly one transaction carrying status, removed count and entry count.
// A request is taken only while the engine is idle. Inserts and
// deletes at a position shift the entries behind that position through the
// RAM's single read and write port, one entry per cycle; delete by value
// reads every entry once; a dump streams one entry per cycle while the
// result register can take it, and otherwise holds until the receiver
// accepts.
// A result register decouples the two sides: a new request is accepted while
// the previous result waits; a stalled receiver holds the engine only when
// its next result is ready to leave.
// Reset empties the list at once (count cleared); the RAM needs no clearing.
module ordered_list_engine #(
    parameter int CAPACITY = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [2:0]                          s_req_type,
    input  logic signed [31:0]                  s_item_value,
    input  logic [4:0]                          s_position,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [31:0]                  m_out_value,
    output logic [olist_pkg::INDEX_W-1:0]       m_out_index,
    output logic [olist_pkg::COUNT_W-1:0]       m_removed,
    output logic [olist_pkg::COUNT_W-1:0]       m_entry_count,
    output logic [1:0]                          m_status,
    output logic                                m_last
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_INS   = 3'd1;
    localparam logic [2:0] S_DELP  = 3'd2;
    localparam logic [2:0] S_DELV  = 3'd3;
    localparam logic [2:0] S_DUMP  = 3'd4;
    localparam logic [2:0] S_REPLY = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [CW-1:0]       count_reg, count_next;
    logic [CW-1:0]       ptr_reg, ptr_next;
    logic [CW-1:0]       j_reg, j_next;
    logic [CW-1:0]       pos_reg, pos_next;
    olist_pkg::value_t   value_reg, value_next;
    logic [CW-1:0]       removed_reg, removed_next;
    logic [1:0]          status_reg, status_next;
    logic                pend_reg, pend_next;
    logic [AW-1:0]       pend_addr_reg, pend_addr_next;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    olist_pkg::value_t   mem_wdata;
    logic                mem_re;
    logic [AW-1:0]       mem_raddr;
    olist_pkg::value_t   mem_rdata;

    logic                out_free;
    logic                out_load;
    olist_pkg::value_t   ld_value;
    logic [olist_pkg::INDEX_W-1:0] ld_index;
    logic [CW-1:0]       ld_removed;
    logic [CW-1:0]       ld_count;
    logic [1:0]          ld_status;
    logic                ld_last;
    int                  dump_len;

    logic                m_valid_reg;
    olist_pkg::value_t   m_value_reg;
    logic [olist_pkg::INDEX_W-1:0] m_index_reg;
    logic [CW-1:0]       m_removed_reg;
    logic [CW-1:0]       m_count_reg;
    logic [1:0]          m_status_reg;
    logic                m_last_reg;

    olist_mem #(
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign dump_len = (int'(count_reg) > olist_pkg::MAX_RESULTS) ?
                      olist_pkg::MAX_RESULTS : int'(count_reg);

    // Sequencer: read, move, write back one entry per cycle unless a dump stalls
    always_comb begin
        state_next     = state_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        j_next         = j_reg;
        pos_next       = pos_reg;
        value_next     = value_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        pend_next      = pend_reg;
        pend_addr_next = pend_addr_reg;
        mem_we         = 1'b0;
        mem_waddr      = '0;
        mem_wdata      = '0;
        mem_re         = 1'b0;
        mem_raddr      = '0;
        out_load       = 1'b0;
        ld_value       = '0;
        ld_index       = '0;
        ld_removed     = '0;
        ld_count       = count_reg;
        ld_status      = olist_pkg::ST_OK;
        ld_last        = 1'b1;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    value_next   = s_item_value;
                    removed_next = '0;
                    status_next  = olist_pkg::ST_OK;
                    ptr_next     = '0;
                    j_next       = '0;
                    pend_next    = 1'b0;
                    unique case (s_req_type) inside
                        olist_pkg::REQ_INS_HEAD, olist_pkg::REQ_INS_TAIL,
                        olist_pkg::REQ_INS_POS: begin
                            if (s_req_type == olist_pkg::REQ_INS_POS &&
                                int'(s_position) > int'(count_reg)) begin
                                status_next = olist_pkg::ST_RANGE;
                                state_next  = S_REPLY;
                            end else if (int'(count_reg) >= CAPACITY) begin
                                status_next = olist_pkg::ST_FULL;
                                state_next  = S_REPLY;
                            end else begin
                                if (s_req_type == olist_pkg::REQ_INS_HEAD) begin
                                    pos_next = '0;
                                end else if (s_req_type == olist_pkg::REQ_INS_TAIL) begin
                                    pos_next = count_reg;
                                end else begin
                                    pos_next = CW'(s_position);
                                end
                                ptr_next   = count_reg;
                                state_next = S_INS;
                            end
                        end
                        olist_pkg::REQ_DEL_POS: begin
                            if (count_reg == '0) begin
                                status_next = olist_pkg::ST_EMPTY;
                                state_next  = S_REPLY;
                            end else if (int'(s_position) >= int'(count_reg)) begin
                                status_next = olist_pkg::ST_RANGE;
                                state_next  = S_REPLY;
                            end else begin
                                pos_next   = CW'(s_position);
                                ptr_next   = CW'(s_position) + CW'(1);
                                state_next = S_DELP;
                            end
                        end
                        olist_pkg::REQ_DEL_VAL: begin
                            if (count_reg == '0) begin
                                status_next = olist_pkg::ST_EMPTY;
                                state_next  = S_REPLY;
                            end else begin
                                state_next = S_DELV;
                            end
                        end
                        olist_pkg::REQ_DUMP: begin
                            if (count_reg == '0) begin
                                status_next = olist_pkg::ST_EMPTY;
                                state_next  = S_REPLY;
                            end else begin
                                state_next = S_DUMP;
                            end
                        end
                        default: begin
                            state_next = S_REPLY;
                        end
                    endcase
                end
            end

            // Shift entries up towards the tail, then drop the new word in
            S_INS: begin
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg + AW'(1);
                    mem_wdata = mem_rdata;
                    pend_next = 1'b0;
                end
                if (ptr_reg > pos_reg) begin
                    mem_re         = 1'b1;
                    mem_raddr      = AW'(ptr_reg - CW'(1));
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(ptr_reg - CW'(1));
                    ptr_next       = ptr_reg - CW'(1);
                end else if (!pend_reg) begin
                    mem_we     = 1'b1;
                    mem_waddr  = AW'(pos_reg);
                    mem_wdata  = value_reg;
                    count_next = count_reg + CW'(1);
                    state_next = S_REPLY;
                end
            end

            // Close the gap by moving later entries down one place
            S_DELP: begin
                if (pend_reg) begin
                    mem_we    = 1'b1;
                    mem_waddr = pend_addr_reg - AW'(1);
                    mem_wdata = mem_rdata;
                    pend_next = 1'b0;
                end
                if (ptr_reg < count_reg) begin
                    mem_re         = 1'b1;
                    mem_raddr      = AW'(ptr_reg);
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(ptr_reg);
                    ptr_next       = ptr_reg + CW'(1);
                end else if (!pend_reg) begin
                    count_next   = count_reg - CW'(1);
                    removed_next = CW'(1);
                    state_next   = S_REPLY;
                end
            end

            // Compact in place: keep non-matching entries at the write index
            S_DELV: begin
                if (pend_reg) begin
                    pend_next = 1'b0;
                    if (mem_rdata != value_reg) begin
                        mem_we    = 1'b1;
                        mem_waddr = AW'(j_reg);
                        mem_wdata = mem_rdata;
                        j_next    = j_reg + CW'(1);
                    end
                end
                if (ptr_reg < count_reg) begin
                    mem_re         = 1'b1;
                    mem_raddr      = AW'(ptr_reg);
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(ptr_reg);
                    ptr_next       = ptr_reg + CW'(1);
                end else if (!pend_reg) begin
                    removed_next = count_reg - j_reg;
                    count_next   = j_reg;
                    state_next   = S_REPLY;
                end
            end

            // Stream entries out, one read in flight ahead of the result register
            S_DUMP: begin
                if (pend_reg && out_free) begin
                    out_load  = 1'b1;
                    ld_value  = mem_rdata;
                    ld_index  = olist_pkg::INDEX_W'(pend_addr_reg);
                    ld_last   = (int'(pend_addr_reg) + 1 == dump_len);
                    pend_next = 1'b0;
                end
                if (int'(ptr_reg) < dump_len && (!pend_reg || out_free)) begin
                    mem_re         = 1'b1;
                    mem_raddr      = AW'(ptr_reg);
                    pend_next      = 1'b1;
                    pend_addr_next = AW'(ptr_reg);
                    ptr_next       = ptr_reg + CW'(1);
                end else if (!pend_reg && int'(ptr_reg) >= dump_len) begin
                    state_next = S_IDLE;
                end
            end

            S_REPLY: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    ld_removed = removed_reg;
                    ld_status  = status_reg;
                    state_next = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        ptr_reg       <= ptr_next;
        j_reg         <= j_next;
        pos_reg       <= pos_next;
        value_reg     <= value_next;
        removed_reg   <= removed_next;
        status_reg    <= status_next;
        pend_addr_reg <= pend_addr_next;
        if (out_load) begin
            m_value_reg   <= ld_value;
            m_index_reg   <= ld_index;
            m_removed_reg <= ld_removed;
            m_count_reg   <= ld_count;
            m_status_reg  <= ld_status;
            m_last_reg    <= ld_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_value   = m_value_reg;
    assign m_out_index   = m_index_reg;
    assign m_removed     = olist_pkg::COUNT_W'(m_removed_reg);
    assign m_entry_count = olist_pkg::COUNT_W'(m_count_reg);
    assign m_status      = m_status_reg;
    assign m_last        = m_last_reg;

endmodule

// File: src/olist_mem.sv
module olist_mem #(
    parameter int DEPTH = 16,
    parameter int AW    = 4
) (
    input  logic               aclk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  olist_pkg::value_t  wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output olist_pkg::value_t  rdata
);

    olist_pkg::value_t mem [DEPTH];
    olist_pkg::value_t rdata_reg;

    // One write port, one registered read port; a read sees the old contents
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
